// ===== src/block_motion_bitmap_macros.svh =====
// Assertion macros used by the block motion bitmap top level.
`ifndef BLOCK_MOTION_BITMAP_MACROS_SVH
`define BLOCK_MOTION_BITMAP_MACROS_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define BMB_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("block_motion_bitmap: same-cycle check failed");

// Next-cycle implication, checked at the rising clock edge outside reset.
`define BMB_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("block_motion_bitmap: next-cycle check failed");

`endif

// ===== src/bmb_pkg.sv =====
`default_nettype none
package bmb_pkg;

   localparam int MAX_DIVISIONS = 8;
   localparam int MAX_FRAME_DIM = 2048;
   localparam int NUM_SECTIONS  = MAX_DIVISIONS * MAX_DIVISIONS;
   localparam int SEC_IDX_W     = $clog2(NUM_SECTIONS);
   localparam int SEC_POS_W     = $clog2(MAX_DIVISIONS);
   localparam int POS_W         = $clog2(MAX_FRAME_DIM);
   localparam int DIM_W         = 12;
   localparam int DIV_W         = 4;
   localparam int COUNT_W       = 23;
   localparam int MIN_COUNT_W   = 22;
   localparam int PIXEL_W       = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 22;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COLS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ROWS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_DIVISIONS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION_ROWS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION_COLS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CHANGED    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_THRESHOLD = 3'd6;

   // Register values after reset.
   localparam logic [DIM_W-1:0]       RST_FRAME_COLS     = 12'd320;
   localparam logic [DIM_W-1:0]       RST_FRAME_ROWS     = 12'd180;
   localparam logic [DIV_W-1:0]       RST_GRID_DIVISIONS = 4'd8;
   localparam logic [DIM_W-1:0]       RST_SECTION_ROWS   = 12'd23;
   localparam logic [DIM_W-1:0]       RST_SECTION_COLS   = 12'd41;
   localparam logic [MIN_COUNT_W-1:0] RST_MIN_CHANGED    = 22'd450;
   localparam logic [PIXEL_W-1:0]     RST_DIFF_THRESHOLD = 8'd10;

   // One classified pixel, handed from the position tracker to the counters.
   typedef struct packed {
      logic                 counted;
      logic [SEC_IDX_W-1:0] idx;
      logic                 last;
   } pix_type;

   // Divisions limited to the largest grid the counters cover.
   function automatic logic [DIV_W-1:0] eff_divisions(input logic [DIV_W-1:0] d);
      if (d > DIV_W'(MAX_DIVISIONS)) begin
         return DIV_W'(MAX_DIVISIONS);
      end
      return d;
   endfunction

   // One bit for every section index below divisions squared.
   function automatic logic [NUM_SECTIONS-1:0] section_mask(input logic [DIV_W-1:0] d);
      logic [2*DIV_W-1:0]      area;
      logic [NUM_SECTIONS-1:0] m;
      area = d * d;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
         m[i] = (2*DIV_W)'(i) < area;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== src/bmb_pos_track.sv =====
`default_nettype none
module bmb_pos_track (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               accept,
   input  wire                               advance,
   input  wire [bmb_pkg::PIXEL_W-1:0]        prev_pixel,
   input  wire [bmb_pkg::PIXEL_W-1:0]        curr_pixel,
   input  wire [bmb_pkg::DIM_W-1:0]          frame_cols,
   input  wire [bmb_pkg::DIM_W-1:0]          frame_rows,
   input  wire [bmb_pkg::DIV_W-1:0]          divisions,
   input  wire [bmb_pkg::DIM_W-1:0]          section_rows,
   input  wire [bmb_pkg::DIM_W-1:0]          section_cols,
   input  wire [bmb_pkg::PIXEL_W-1:0]        diff_threshold,
   output logic                              stage_valid,
   output bmb_pkg::pix_type                  stage_pix
);
   import bmb_pkg::*;

   logic [POS_W-1:0]     pixel_col_ff, pixel_col_in;
   logic [POS_W-1:0]     pixel_row_ff, pixel_row_in;
   logic [DIM_W-1:0]     col_in_sec_ff, col_in_sec_in;
   logic [DIM_W-1:0]     row_in_sec_ff, row_in_sec_in;
   logic [SEC_POS_W-1:0] sec_col_ff, sec_col_in;
   logic [SEC_POS_W-1:0] sec_row_ff, sec_row_in;
   logic                 stage_valid_ff, stage_valid_in;
   pix_type              stage_pix_ff, stage_pix_in;

   logic [DIM_W-1:0]     cols, rows, scols, srows;
   logic [PIXEL_W-1:0]   diff;
   logic [2*SEC_POS_W-1:0] row_base;
   logic                 row_end, frame_end;

   always_comb begin
      cols = (frame_cols == '0) ? DIM_W'(1) :
             (frame_cols > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : frame_cols;
      rows = (frame_rows == '0) ? DIM_W'(1) :
             (frame_rows > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : frame_rows;
      scols = (section_cols == '0) ? DIM_W'(1) : section_cols;
      srows = (section_rows == '0) ? DIM_W'(1) : section_rows;

      diff = (prev_pixel > curr_pixel) ? prev_pixel - curr_pixel : curr_pixel - prev_pixel;
      row_base = sec_row_ff * divisions[SEC_POS_W-1:0];
      if (divisions == DIV_W'(MAX_DIVISIONS)) begin
         row_base = {sec_row_ff, {SEC_POS_W{1'b0}}};
      end

      row_end   = ({1'b0, pixel_col_ff} + DIM_W'(1)) >= cols;
      frame_end = row_end && (({1'b0, pixel_row_ff} + DIM_W'(1)) >= rows);

      stage_pix_in.counted = (diff > diff_threshold)
                             && ({1'b0, sec_row_ff} < divisions)
                             && ({1'b0, sec_col_ff} < divisions);
      stage_pix_in.idx     = SEC_IDX_W'(row_base + {{SEC_POS_W{1'b0}}, sec_col_ff});
      stage_pix_in.last    = frame_end;

      pixel_col_in  = pixel_col_ff;
      pixel_row_in  = pixel_row_ff;
      col_in_sec_in = col_in_sec_ff;
      row_in_sec_in = row_in_sec_ff;
      sec_col_in    = sec_col_ff;
      sec_row_in    = sec_row_ff;
      if (accept) begin
         if (frame_end) begin
            pixel_col_in  = '0;
            pixel_row_in  = '0;
            col_in_sec_in = '0;
            row_in_sec_in = '0;
            sec_col_in    = '0;
            sec_row_in    = '0;
         end else if (row_end) begin
            pixel_col_in  = '0;
            col_in_sec_in = '0;
            sec_col_in    = '0;
            pixel_row_in  = pixel_row_ff + POS_W'(1);
            if (({1'b0, row_in_sec_ff} + (DIM_W+1)'(1)) >= {1'b0, srows}) begin
               row_in_sec_in = '0;
               if (sec_row_ff != SEC_POS_W'(MAX_DIVISIONS - 1)) begin
                  sec_row_in = sec_row_ff + SEC_POS_W'(1);
               end
            end else begin
               row_in_sec_in = row_in_sec_ff + DIM_W'(1);
            end
         end else begin
            pixel_col_in = pixel_col_ff + POS_W'(1);
            if (({1'b0, col_in_sec_ff} + (DIM_W+1)'(1)) >= {1'b0, scols}) begin
               col_in_sec_in = '0;
               if (sec_col_ff != SEC_POS_W'(MAX_DIVISIONS - 1)) begin
                  sec_col_in = sec_col_ff + SEC_POS_W'(1);
               end
            end else begin
               col_in_sec_in = col_in_sec_ff + DIM_W'(1);
            end
         end
      end

      stage_valid_in = advance ? accept : stage_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_col_ff   <= '0;
         pixel_row_ff   <= '0;
         col_in_sec_ff  <= '0;
         row_in_sec_ff  <= '0;
         sec_col_ff     <= '0;
         sec_row_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         pixel_col_ff   <= pixel_col_in;
         pixel_row_ff   <= pixel_row_in;
         col_in_sec_ff  <= col_in_sec_in;
         row_in_sec_ff  <= row_in_sec_in;
         sec_col_ff     <= sec_col_in;
         sec_row_ff     <= sec_row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_pix_ff <= stage_pix_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_pix   = stage_pix_ff;

endmodule
`default_nettype wire

// ===== src/bmb_count_array.sv =====
`default_nettype none
module bmb_count_array (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 step,
   input  wire bmb_pkg::pix_type               pix,
   input  wire [bmb_pkg::MIN_COUNT_W-1:0]      min_count,
   input  wire [bmb_pkg::NUM_SECTIONS-1:0]     mask,
   output logic [bmb_pkg::NUM_SECTIONS-1:0]    bits
);
   import bmb_pkg::*;

   logic [COUNT_W-1:0] cnt_ff [NUM_SECTIONS];
   logic [COUNT_W-1:0] cnt_in [NUM_SECTIONS];
   logic [COUNT_W-1:0] after  [NUM_SECTIONS];

   // Each section counter is its own cell; the bitmap looks at the counts
   // including the pixel that ends the frame.
   always_comb begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
         after[i] = cnt_ff[i];
         if (step && pix.counted && (pix.idx == SEC_IDX_W'(i)) && (cnt_ff[i] != COUNT_MAX)) begin
            after[i] = cnt_ff[i] + COUNT_W'(1);
         end
         bits[i]   = mask[i] && (after[i] >= {1'b0, min_count});
         cnt_in[i] = (step && pix.last) ? '0 : after[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/block_motion_bitmap.sv =====
// Block motion bitmap.
// Pixel pairs (previous and current grey level of the same position) enter
// on the req_ channel in raster order, one transfer per pixel. A transfer
// takes place at a rising edge with req_valid high and req_stall low.
// Each pixel whose absolute difference exceeds the threshold bumps the
// counter of its grid section. The transfer of the last pixel of a frame
// produces one rsp_ transfer carrying the 64-bit section bitmap and a flag
// that is set when any bit is set; all other pixels produce nothing.
// Throughput is one pixel per clock while req_stall is low. The edge that
// transfers the last pixel loads the classification register, and the edge
// that moves that pixel into the counters updates them and loads the result
// register, which raises rsp_valid.
// When the receiver stalls, the result waits in the output register and
// pixels keep flowing into the counters; req_stall rises only if a second
// frame end reaches the counters while the first result is still held.
// Configuration is a plain write port (csr_we, csr_index, csr_wdata). The user
// writes it only while the block is idle; the block does not enforce this.
// Synchronous reset loads the default register values, clears the frame
// position and all counters, and empties the pipeline and result register.
`default_nettype none
`include "block_motion_bitmap_macros.svh"
module block_motion_bitmap (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [bmb_pkg::PIXEL_W-1:0]         req_prev_pixel,
   input  wire [bmb_pkg::PIXEL_W-1:0]         req_curr_pixel,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [bmb_pkg::NUM_SECTIONS-1:0]   rsp_motion_bits,
   output logic                               rsp_any_motion,
   input  wire                                csr_we,
   input  wire [bmb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [bmb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bmb_pkg::*;

   // Configuration registers.
   logic [DIM_W-1:0]       frame_cols_ff;
   logic [DIM_W-1:0]       frame_rows_ff;
   logic [DIV_W-1:0]       divisions_ff;
   logic [DIM_W-1:0]       section_rows_ff;
   logic [DIM_W-1:0]       section_cols_ff;
   logic [MIN_COUNT_W-1:0] min_count_ff;
   logic [PIXEL_W-1:0]     threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff   <= RST_FRAME_COLS;
         frame_rows_ff   <= RST_FRAME_ROWS;
         divisions_ff    <= RST_GRID_DIVISIONS;
         section_rows_ff <= RST_SECTION_ROWS;
         section_cols_ff <= RST_SECTION_COLS;
         min_count_ff    <= RST_MIN_CHANGED;
         threshold_ff    <= RST_DIFF_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_COLS:     frame_cols_ff   <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_ROWS:     frame_rows_ff   <= csr_wdata[DIM_W-1:0];
            CSR_GRID_DIVISIONS: divisions_ff    <= csr_wdata[DIV_W-1:0];
            CSR_SECTION_ROWS:   section_rows_ff <= csr_wdata[DIM_W-1:0];
            CSR_SECTION_COLS:   section_cols_ff <= csr_wdata[DIM_W-1:0];
            CSR_MIN_CHANGED:    min_count_ff    <= csr_wdata[MIN_COUNT_W-1:0];
            CSR_DIFF_THRESHOLD: threshold_ff    <= csr_wdata[PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DIV_W-1:0]        div_eff;
   logic [NUM_SECTIONS-1:0] sec_mask;

   assign div_eff  = eff_divisions(divisions_ff);
   assign sec_mask = section_mask(div_eff);

   // The classified pixel may move into the counters unless it ends a frame
   // while the previous result is still held by a stalled receiver.
   logic    stage_valid;
   pix_type stage_pix;
   logic    blocked;
   logic    advance;
   logic    req_accept;
   logic    frame_done;

   assign blocked    = stage_valid && stage_pix.last && rsp_valid && rsp_stall;
   assign advance    = !blocked;
   assign req_stall  = blocked;
   assign req_accept = req_valid && !req_stall;
   assign frame_done = stage_valid && advance && stage_pix.last;

   bmb_pos_track u_pos_track (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .advance        (advance),
      .prev_pixel     (req_prev_pixel),
      .curr_pixel     (req_curr_pixel),
      .frame_cols     (frame_cols_ff),
      .frame_rows     (frame_rows_ff),
      .divisions      (div_eff),
      .section_rows   (section_rows_ff),
      .section_cols   (section_cols_ff),
      .diff_threshold (threshold_ff),
      .stage_valid    (stage_valid),
      .stage_pix      (stage_pix)
   );

   logic [NUM_SECTIONS-1:0] frame_bits;

   bmb_count_array u_count_array (
      .clock     (clock),
      .reset     (reset),
      .step      (stage_valid && advance),
      .pix       (stage_pix),
      .min_count (min_count_ff),
      .mask      (sec_mask),
      .bits      (frame_bits)
   );

   // Result register: it is loaded at a frame end and released by a transfer.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUM_SECTIONS-1:0] rsp_bits_ff;
   logic                    rsp_any_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_bits_ff <= frame_bits;
         rsp_any_ff  <= frame_bits != '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motion_bits = rsp_bits_ff;
   assign rsp_any_motion  = rsp_any_ff;

   // The input side only ever waits on a held result.
   `BMB_ASSERT_SAME(a_stall_only_on_held_result, clock, reset, req_stall, rsp_valid && rsp_stall)
   // A frame end reaching the counters always yields a result next cycle.
   `BMB_ASSERT_NEXT(a_frame_end_gives_result, clock, reset, frame_done, rsp_valid)
   // The summary flag agrees with the bitmap it was loaded with.
   `BMB_ASSERT_SAME(a_any_matches_bits, clock, reset, rsp_valid, rsp_any_motion == (rsp_motion_bits != '0))

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import bmb_pkg::*;

   // Pixel pairs go into a queue from the stimulus process. A clocked driver
   // offers them on the req_ channel, and each accepted transfer is run through
   // a cycle-free predictor of the frame walk and section counters. When that
   // predictor reaches the end of a frame it queues the expected bitmap. The
   // monitor checks every rsp_ transfer against the oldest pending bitmap.
   //
   // Registers are only written with the block idle, meaning nothing is queued
   // or offered, nothing is expected, and the pipeline has had time to drain.
   // A phase may stop in the middle of a frame. The new settings then apply to
   // a walk already under way, which is how the block behaves when its
   // registers change mid-frame.

   localparam int unsigned DRAIN_CYCLES   = 6;    // two pipeline stages plus margin
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned RANDOM_PIXELS  = 400;
   localparam int unsigned RANDOM_FRAMES  = 25;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [PIXEL_W-1:0] prev;
      logic [PIXEL_W-1:0] curr;
   } pixel_pair_type;

   typedef struct {
      logic [NUM_SECTIONS-1:0] bits;
      logic                    any;
   } motion_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [PIXEL_W-1:0]      req_prev_pixel = '0;
   logic [PIXEL_W-1:0]      req_curr_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [NUM_SECTIONS-1:0] rsp_motion_bits;
   logic                    rsp_any_motion;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   block_motion_bitmap dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_prev_pixel  (req_prev_pixel),
      .req_curr_pixel  (req_curr_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_motion_bits (rsp_motion_bits),
      .rsp_any_motion  (rsp_any_motion),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Pixels waiting to be offered, and bitmaps waiting to come back.
   pixel_pair_type    pixel_queue[$];
   motion_result_type expected_bitmaps[$];

   // Pacing. The stimulus process moves these through the three idle regimes.
   int unsigned sender_idle_pct   = 23;
   int unsigned receiver_idle_pct = 79;

   int unsigned mismatch_count   = 0;
   int unsigned bitmaps_checked  = 0;
   int unsigned pixels_accepted  = 0;
   int unsigned input_held_count = 0;
   int unsigned settings_count   = 0;
   int unsigned hold_left        = 0;
   bit          hold_done        = 1'b0;
   bit          hold_request     = 1'b0;

   // Predictor copy of the registers, masked to their hardware widths.
   logic [DIM_W-1:0]       cfg_frame_cols;
   logic [DIM_W-1:0]       cfg_frame_rows;
   logic [DIV_W-1:0]       cfg_divisions;
   logic [DIM_W-1:0]       cfg_section_rows;
   logic [DIM_W-1:0]       cfg_section_cols;
   logic [MIN_COUNT_W-1:0] cfg_min_changed;
   logic [PIXEL_W-1:0]     cfg_threshold;

   // Predictor copy of the frame walk and of the per-section counters.
   logic [POS_W-1:0]     walk_col;
   logic [POS_W-1:0]     walk_row;
   logic [DIM_W-1:0]     col_in_sec;
   logic [DIM_W-1:0]     row_in_sec;
   logic [SEC_POS_W-1:0] sec_col;
   logic [SEC_POS_W-1:0] sec_row;
   logic [COUNT_W-1:0]   changed_counts [NUM_SECTIONS];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic clear_frame_walk();
      walk_col   = '0;
      walk_row   = '0;
      col_in_sec = '0;
      row_in_sec = '0;
      sec_col    = '0;
      sec_row    = '0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
         changed_counts[i] = '0;
      end
   endtask

   // Advances the frame walk by one accepted pixel. On the last pixel of a
   // frame, the bitmap that the block must return is queued.
   task automatic count_pixel(input logic [PIXEL_W-1:0] prev, input logic [PIXEL_W-1:0] curr);
      int unsigned       diff;
      int unsigned       divs;
      int unsigned       cols;
      int unsigned       rows;
      int unsigned       scols;
      int unsigned       srows;
      int unsigned       idx;
      motion_result_type res;
      diff  = (prev > curr) ? prev - curr : curr - prev;
      divs  = (cfg_divisions > MAX_DIVISIONS) ? MAX_DIVISIONS : cfg_divisions;
      cols  = (cfg_frame_cols == 0) ? 1 :
              (cfg_frame_cols > MAX_FRAME_DIM) ? MAX_FRAME_DIM : cfg_frame_cols;
      rows  = (cfg_frame_rows == 0) ? 1 :
              (cfg_frame_rows > MAX_FRAME_DIM) ? MAX_FRAME_DIM : cfg_frame_rows;
      scols = (cfg_section_cols == 0) ? 1 : cfg_section_cols;
      srows = (cfg_section_rows == 0) ? 1 : cfg_section_rows;

      // Pixels in sections beyond the grid are never counted.
      if (diff > cfg_threshold && sec_row < divs && sec_col < divs) begin
         idx = (sec_row * divs + sec_col) % NUM_SECTIONS;
         if (changed_counts[idx] != COUNT_MAX) begin
            changed_counts[idx] = changed_counts[idx] + 1'b1;
         end
      end

      if (walk_col + 1 >= cols) begin
         walk_col   = '0;
         col_in_sec = '0;
         sec_col    = '0;
         if (walk_row + 1 >= rows) begin
            res.bits = '0;
            for (int i = 0; i < divs * divs; i++) begin
               if (changed_counts[i] >= cfg_min_changed) begin
                  res.bits[i] = 1'b1;
               end
            end
            res.any = |res.bits;
            expected_bitmaps.insert(expected_bitmaps.size(), res);
            clear_frame_walk();
            return;
         end
         walk_row = walk_row + 1'b1;
         if (row_in_sec + 1 >= srows) begin
            row_in_sec = '0;
            // The section row sticks at the last grid row instead of wrapping.
            if (sec_row < MAX_DIVISIONS - 1) begin
               sec_row = sec_row + 1'b1;
            end
         end else begin
            row_in_sec = row_in_sec + 1'b1;
         end
      end else begin
         walk_col = walk_col + 1'b1;
         if (col_in_sec + 1 >= scols) begin
            col_in_sec = '0;
            if (sec_col < MAX_DIVISIONS - 1) begin
               sec_col = sec_col + 1'b1;
            end
         end else begin
            col_in_sec = col_in_sec + 1'b1;
         end
      end
   endtask

   // Driver. A new pixel is offered only once the previous one has been taken
   // (or nothing was offered), so a stalled payload never changes. Each
   // accepted transfer goes through the predictor right here, at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            count_pixel(req_prev_pixel, req_curr_pixel);
            pixels_accepted <= pixels_accepted + 1;
         end
         if (req_valid && req_stall) begin
            input_held_count <= input_held_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               req_valid      <= 1'b1;
               req_prev_pixel <= pixel_queue[0].prev;
               req_curr_pixel <= pixel_queue[0].curr;
               void'(pixel_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall. When the stimulus asks for it, the receiver holds off for
   // one long stretch while the sender keeps going, so that a second frame
   // end lands on a held result and the block has to stall its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
      end
   end

   // Monitor: every result transfer is matched against the oldest bitmap.
   always @(posedge clock) begin
      motion_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bitmaps.size() == 0) begin
            report_mismatch($sformatf("unexpected bitmap %h", rsp_motion_bits));
         end else begin
            want = expected_bitmaps.pop_front();
            bitmaps_checked++;
            if (rsp_motion_bits !== want.bits) begin
               report_mismatch($sformatf("motion_bits %h, predicted %h",
                                         rsp_motion_bits, want.bits));
            end
            if (rsp_any_motion !== want.any) begin
               report_mismatch($sformatf("any_motion %b, predicted %b",
                                         rsp_any_motion, want.any));
            end
         end
      end
   end

   // Waits until no pixel is queued or offered and no bitmap is outstanding,
   // then lets the pipeline drain in case the last pixels ended no frame.
   task automatic settle();
      while (pixel_queue.size() != 0 || req_valid || expected_bitmaps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write. Data bits above the register's width get random
   // filler so that every bit of the write data toggles; the block drops them.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] fill;
      logic [CSR_DATA_W-1:0] data;
      int unsigned           width;
      case (idx)
         CSR_GRID_DIVISIONS: width = DIV_W;
         CSR_MIN_CHANGED:    width = MIN_COUNT_W;
         CSR_DIFF_THRESHOLD: width = PIXEL_W;
         default:            width = DIM_W;
      endcase
      keep = (CSR_DATA_W'(1) << width) - 1'b1;
      fill = $urandom_range(1, 0) ? CSR_DATA_W'($urandom) : '0;
      data = (CSR_DATA_W'(value) & keep) | (fill & ~keep);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_FRAME_COLS:     cfg_frame_cols   = data[DIM_W-1:0];
         CSR_FRAME_ROWS:     cfg_frame_rows   = data[DIM_W-1:0];
         CSR_GRID_DIVISIONS: cfg_divisions    = data[DIV_W-1:0];
         CSR_SECTION_ROWS:   cfg_section_rows = data[DIM_W-1:0];
         CSR_SECTION_COLS:   cfg_section_cols = data[DIM_W-1:0];
         CSR_MIN_CHANGED:    cfg_min_changed  = data[MIN_COUNT_W-1:0];
         CSR_DIFF_THRESHOLD: cfg_threshold    = data[PIXEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits for idle, then loads a whole register setting.
   task automatic program_grid(input int unsigned cols, input int unsigned rows,
                               input int unsigned divs, input int unsigned srows,
                               input int unsigned scols, input int unsigned minc,
                               input int unsigned thr);
      settle();
      write_reg(CSR_FRAME_COLS, cols);
      write_reg(CSR_FRAME_ROWS, rows);
      write_reg(CSR_GRID_DIVISIONS, divs);
      write_reg(CSR_SECTION_ROWS, srows);
      write_reg(CSR_SECTION_COLS, scols);
      write_reg(CSR_MIN_CHANGED, minc);
      write_reg(CSR_DIFF_THRESHOLD, thr);
      close_writes();
      settings_count++;
   endtask

   task automatic push_pair(input logic [PIXEL_W-1:0] prev, input logic [PIXEL_W-1:0] curr);
      pixel_queue.insert(pixel_queue.size(), {prev, curr});
   endtask

   // A pixel pair that is changed with the given likelihood. Differences of
   // exactly the threshold and one above it come up often, and a share of
   // pairs is plain noise.
   function automatic pixel_pair_type make_pixel(input int unsigned thr,
                                                 input int unsigned motion_pct);
      int unsigned diff;
      int unsigned lo;
      if ($urandom_range(99, 0) < 8) begin
         return {PIXEL_W'($urandom), PIXEL_W'($urandom)};
      end
      if ($urandom_range(99, 0) < motion_pct && thr < 255) begin
         diff = ($urandom_range(3, 0) == 0) ? thr + 1 : $urandom_range(255, thr + 1);
      end else begin
         diff = ($urandom_range(3, 0) == 0) ? thr : $urandom_range(thr, 0);
      end
      lo = $urandom_range(255 - diff, 0);
      if ($urandom_range(1, 0)) begin
         return {PIXEL_W'(lo), PIXEL_W'(lo + diff)};
      end
      return {PIXEL_W'(lo + diff), PIXEL_W'(lo)};
   endfunction

   int unsigned random_pixels = 0;
   int unsigned frames_queued = 0;

   // One register setting followed by a few small frames of random content.
   task automatic random_phase();
      int unsigned cols, rows, divs, srows, scols, minc, thr;
      int unsigned eff_cols, eff_rows, eff_divs, area, sec_area;
      int unsigned frames, motion, extra, pick;
      pick   = $urandom_range(99, 0);
      divs   = (pick < 5) ? 0 : (pick < 12) ? $urandom_range(15, 9) : $urandom_range(8, 1);
      cols   = ($urandom_range(99, 0) < 4) ? 0 : $urandom_range(8, 1);
      rows   = ($urandom_range(99, 0) < 4) ? 0 : $urandom_range(6, 1);
      frames = $urandom_range(5, 2);
      eff_cols = (cols == 0) ? 1 : (cols > MAX_FRAME_DIM) ? MAX_FRAME_DIM : cols;
      eff_rows = (rows == 0) ? 1 : (rows > MAX_FRAME_DIM) ? MAX_FRAME_DIM : rows;
      eff_divs = (divs == 0) ? 1 : (divs > MAX_DIVISIONS) ? MAX_DIVISIONS : divs;
      // Mostly what software would load; sometimes odd sizes, zero among them.
      scols = ($urandom_range(99, 0) < 80) ? eff_cols / eff_divs + 1 : $urandom_range(4, 0);
      srows = ($urandom_range(99, 0) < 80) ? eff_rows / eff_divs + 1 : $urandom_range(4, 0);
      sec_area = ((scols > eff_cols) ? eff_cols : (scols == 0) ? 1 : scols) *
                 ((srows > eff_rows) ? eff_rows : (srows == 0) ? 1 : srows);
      pick = $urandom_range(99, 0);
      minc = (pick < 4) ? (1 << MIN_COUNT_W) - 1 : (pick < 10) ? 0 : $urandom_range(sec_area, 0);
      pick = $urandom_range(99, 0);
      thr  = (pick < 10) ? 0 : (pick < 18) ? 255 : $urandom_range(255, 0);
      program_grid(cols, rows, divs, srows, scols, minc, thr);

      area = eff_cols * eff_rows;
      for (int f = 0; f < frames; f++) begin
         case ($urandom_range(4, 0))
            0:       motion = 0;
            1:       motion = 15;
            2:       motion = 50;
            3:       motion = 85;
            default: motion = 100;
         endcase
         for (int n = 0; n < area; n++) begin
            pixel_queue.insert(pixel_queue.size(), make_pixel(thr, motion));
         end
      end
      // Sometimes stop partway into a frame, so the next setting lands mid-frame.
      extra = 0;
      if (area > 1 && $urandom_range(99, 0) < 20) begin
         extra = $urandom_range(area - 1, 1);
         for (int n = 0; n < extra; n++) begin
            pixel_queue.insert(pixel_queue.size(), make_pixel(thr, 50));
         end
      end
      random_pixels += frames * area + extra;
      frames_queued += frames;
   endtask

   initial begin
      cfg_frame_cols   = RST_FRAME_COLS;
      cfg_frame_rows   = RST_FRAME_ROWS;
      cfg_divisions    = RST_GRID_DIVISIONS;
      cfg_section_rows = RST_SECTION_ROWS;
      cfg_section_cols = RST_SECTION_COLS;
      cfg_min_changed  = RST_MIN_CHANGED;
      cfg_threshold    = RST_DIFF_THRESHOLD;
      clear_frame_walk();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A write to the unused index has to leave every register alone.
      settle();
      write_reg(CSR_UNMAPPED, $urandom);
      close_writes();

      // Two by two grid of one-pixel sections. The pixels are the grey
      // extremes, a difference equal to the threshold (not counted) and
      // one just above it.
      program_grid(2, 2, 2, 1, 1, 1, 10);
      push_pair(8'd0, 8'd255);
      push_pair(8'd255, 8'd0);
      push_pair(8'd20, 8'd10);
      push_pair(8'd0, 8'd11);

      // Zero divisions: nothing is counted and the bitmap is empty.
      program_grid(2, 1, 0, 1, 1, 0, 0);
      push_pair(8'd0, 8'd255);
      push_pair(8'd255, 8'd0);

      // Divisions beyond the maximum, zero frame width, zero section sizes and
      // a zero minimum: with nothing counted, all 64 bits must still be set.
      program_grid(0, 3, 15, 0, 0, 0, 255);
      push_pair(8'd255, 8'd255);
      push_pair(8'd0, 8'd0);
      push_pair(8'd128, 8'd127);

      // One division with one-pixel sections: everything past the first
      // column or row lies outside the grid and must not count.
      program_grid(3, 2, 1, 1, 1, 1, 0);
      push_pair(8'd7, 8'd6);
      push_pair(8'd0, 8'd1);
      push_pair(8'd0, 8'd255);
      push_pair(8'd255, 8'd0);
      push_pair(8'd9, 8'd200);
      push_pair(8'd1, 8'd0);

      // Nine one-pixel sections across an eight-wide grid. The section column
      // sticks at the last one, so columns seven and eight share a counter.
      program_grid(9, 1, 8, 1, 1, 2, 127);
      push_pair(8'd0, 8'd255);
      for (int n = 1; n < 7; n++) begin
         push_pair(8'(n), 8'(n));
      end
      push_pair(8'd255, 8'd0);
      push_pair(8'd0, 8'd128);

      // Frame width shrunk mid-frame. The walk is already past the new width,
      // so the very next pixel ends the frame.
      program_grid(4, 1, 1, 1, 4, 1, 0);
      push_pair(8'd3, 8'd4);
      push_pair(8'd90, 8'd0);
      push_pair(8'd0, 8'd90);
      settle();
      write_reg(CSR_FRAME_COLS, 2);
      close_writes();
      push_pair(8'd50, 8'd50);

      // Single-pixel frames back to back under a long receiver hold-off. Every
      // pixel ends a frame, so the second one finds the result still held and
      // the block has to stall its input until the receiver lets go.
      program_grid(1, 1, 1, 1, 1, 1, 0);
      hold_request = 1'b1;
      for (int n = 0; n < 12; n++) begin
         push_pair(8'(n), 8'(2 * n));
      end

      // Random part. The receiver idles more than the sender for the first
      // stretch, then the other way round, then neither idles at all.
      while (random_pixels < RANDOM_PIXELS || frames_queued < RANDOM_FRAMES) begin
         if (random_pixels >= 2 * RANDOM_PIXELS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (random_pixels >= RANDOM_PIXELS / 3) begin
            sender_idle_pct   = 79;
            receiver_idle_pct = 23;
         end
         random_phase();
      end

      settle();
      $display("Covered %0d pixel transfers over %0d register settings, %0d bitmaps checked.",
               pixels_accepted, settings_count, bitmaps_checked);
      $display("Input held off by the block on %0d cycles; one receiver hold-off of %0d cycles.",
               input_held_count, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Time limit, several times over the slowest legal run.
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== block_motion_bitmap.f =====
+incdir+src
src/bmb_pkg.sv
src/bmb_pos_track.sv
src/bmb_count_array.sv
src/block_motion_bitmap.sv
sim/tb_top.sv
